@@ hw/rtl/lcsm_pkg.sv @@
// shared types and constants of the li chao segment max block
// no dependencies; used by every module of the block
`default_nettype none

package lcsm_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int NODE_DEPTH = 2 * LEAF_COUNT;
    localparam int NODE_W     = $clog2(NODE_DEPTH);
    localparam int PT_W       = 11;
    localparam int CRD_AW     = $clog2(LEAF_COUNT);
    localparam int STK_DEPTH  = 16;
    localparam int SP_W       = $clog2(STK_DEPTH) + 1;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_INSERT = 2'd1,
        K_QUERY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CRD_AW-1:0]  idx;
        logic signed [31:0] coord;
        logic [PT_W-1:0]    lo;
        logic [PT_W-1:0]    hi;
        logic signed [31:0] slope;
        logic signed [63:0] icpt;
        logic [PT_W-1:0]    pt;
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/lcsm_front.sv @@
// front part: input handshake, item classification and a two-entry command queue
// depends on lcsm_pkg
`default_nettype none

module lcsm_front
    import lcsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_mode,
    input  wire logic [9:0]          i_load_index,
    input  wire logic signed [31:0]  i_coord_value,
    input  wire logic [10:0]         i_range_low,
    input  wire logic [10:0]         i_range_high,
    input  wire logic signed [31:0]  i_slope,
    input  wire logic signed [63:0]  i_intercept,
    input  wire logic [10:0]         i_query_point,
    input  wire logic                i_clearing,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  wire logic                i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       n_keep;
    logic       w_acc;
    logic       w_push;

    assign o_stall     = (r_cnt == 2'd2) || i_clearing;
    assign w_acc       = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = w_acc && n_keep;

    always_comb begin
        n_cmd.kind  = K_LOAD;
        n_cmd.idx   = i_load_index;
        n_cmd.coord = i_coord_value;
        n_cmd.lo    = i_range_low;
        n_cmd.hi    = i_range_high;
        n_cmd.slope = i_slope;
        n_cmd.icpt  = i_intercept;
        n_cmd.pt    = i_query_point;
        n_keep      = 1'b0;
        // clamp the query leaf into the tree
        if (i_query_point == 11'd0) begin
            n_cmd.pt = 11'd1;
        end else if (i_query_point > PT_W'(LEAF_COUNT)) begin
            n_cmd.pt = PT_W'(LEAF_COUNT);
        end
        case (t_mode'(i_mode))
            MODE_LOAD: begin
                n_cmd.kind = K_LOAD;
                n_keep     = 1'b1;
            end
            MODE_INSERT: begin
                n_cmd.kind = K_INSERT;
                n_keep     = (i_range_low <= i_range_high);
            end
            MODE_QUERY: begin
                n_cmd.kind = K_QUERY;
                n_keep     = 1'b1;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= n_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcsm_line_eval.sv @@
// line evaluation unit: slope*x then saturating add of the offset; product and sum are registered
// depends on lcsm_pkg
`default_nettype none

module lcsm_line_eval
    import lcsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic signed [31:0]  i_slope,
    input  wire logic signed [31:0]  i_x,
    input  wire logic signed [63:0]  i_offset,
    output logic signed [63:0]       o_value
);

    logic signed [63:0] r_prod;
    logic signed [63:0] r_off;
    logic signed [63:0] r_value;
    logic signed [64:0] w_sum;
    logic signed [63:0] n_value;

    assign w_sum   = {r_prod[63], r_prod} + {r_off[63], r_off};
    assign o_value = r_value;

    always_comb begin
        n_value = w_sum[63:0];
        // top two bits differ on overflow
        if (w_sum[64] != w_sum[63]) begin
            n_value = w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= 64'(i_slope) * 64'(i_x);
        r_off   <= i_offset;
        r_value <= n_value;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcsm_back.sv @@
// back part: sequencer for loads, inserts and queries, node and coordinate memories,
// result register; depends on lcsm_pkg and lcsm_line_eval
`default_nettype none

module lcsm_back
    import lcsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    input  wire t_cmd                i_cmd,
    output logic                     o_cmd_pop,
    output logic                     o_clearing,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [63:0]       o_best_value
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_CLEAR = 17'h00002,
        ST_VISIT = 17'h00004,
        ST_POP   = 17'h00008,
        ST_RD    = 17'h00010,
        ST_X     = 17'h00020,
        ST_E1    = 17'h00040,
        ST_E2    = 17'h00080,
        ST_E3    = 17'h00100,
        ST_DEC   = 17'h00200,
        ST_QA    = 17'h00400,
        ST_QX    = 17'h00800,
        ST_QN    = 17'h01000,
        ST_QE    = 17'h02000,
        ST_QW    = 17'h04000,
        ST_QV    = 17'h08000,
        ST_QOUT  = 17'h10000
    } t_state;

    typedef enum logic [1:0] {
        PT_LO  = 2'd0,
        PT_HI  = 2'd1,
        PT_MID = 2'd2
    } t_pt;

    t_state r_state;
    t_pt    r_p;

    logic [NODE_W-1:0]  r_n;
    logic [PT_W-1:0]    r_lo;
    logic [PT_W-1:0]    r_hi;
    logic [PT_W-1:0]    r_ilo;
    logic [PT_W-1:0]    r_ihi;
    logic [PT_W-1:0]    r_pt;
    logic signed [31:0] r_k;
    logic signed [63:0] r_b;
    logic signed [31:0] r_k0;
    logic signed [63:0] r_b0;
    logic signed [31:0] r_ck;
    logic signed [63:0] r_cb;
    logic signed [31:0] r_x;
    logic signed [63:0] r_ln, r_lc, r_rn, r_rc, r_mn, r_mc;
    logic signed [63:0] r_best;
    logic               r_first;
    logic [NODE_W-1:0]  r_clr;
    logic               r_ovalid;
    logic signed [63:0] r_obest;

    logic [NODE_W-1:0]  r_stk_n  [STK_DEPTH];
    logic [PT_W-1:0]    r_stk_lo [STK_DEPTH];
    logic [PT_W-1:0]    r_stk_hi [STK_DEPTH];
    logic [SP_W-1:0]    r_sp;

    // memories
    logic signed [31:0] r_node_k   [NODE_DEPTH];
    logic signed [63:0] r_node_b   [NODE_DEPTH];
    logic signed [31:0] r_coord    [LEAF_COUNT];
    logic signed [31:0] r_node_k_q;
    logic signed [63:0] r_node_b_q;
    logic signed [31:0] r_coord_q;

    logic               w_node_we;
    logic [NODE_W-1:0]  w_node_wa;
    logic signed [31:0] w_node_wk;
    logic signed [63:0] w_node_wb;
    logic               w_crd_we;
    logic [CRD_AW-1:0]  w_crd_ra;
    logic [PT_W-1:0]    w_rd_pt;

    logic [PT_W:0]      w_sum;
    logic [PT_W-1:0]    w_mid;
    logic               w_cover;
    logic               w_go_l;
    logic               w_go_r;
    logic [NODE_W-1:0]  w_nl;
    logic [NODE_W-1:0]  w_nr;
    logic [SP_W-2:0]    w_top;

    logic               ge_l, le_l, ge_r, le_r, ge_m, le_m;

    logic signed [31:0] e_k;
    logic signed [31:0] e_x;
    logic signed [63:0] e_b;
    logic signed [63:0] e_v;

    lcsm_line_eval u_eval (
        .i_clk    (i_clk),
        .i_slope  (e_k),
        .i_x      (e_x),
        .i_offset (e_b),
        .o_value  (e_v)
    );

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid   = w_sum[PT_W:1];
    assign w_cover = (r_lo >= r_ilo) && (r_hi <= r_ihi);
    assign w_go_l  = (r_lo <= r_ihi) && (w_mid >= r_ilo);
    assign w_go_r  = (w_mid < r_ihi) && (r_hi >= r_ilo);
    assign w_nl    = {r_n[NODE_W-2:0], 1'b0};
    assign w_nr    = {r_n[NODE_W-2:0], 1'b1};
    assign w_top   = r_sp[SP_W-2:0] - 1'b1;

    assign ge_l = (r_lc >= r_ln);
    assign le_l = (r_lc <= r_ln);
    assign ge_r = (r_rc >= r_rn);
    assign le_r = (r_rc <= r_rn);
    assign ge_m = (r_mc >= r_mn);
    assign le_m = (r_mc <= r_mn);

    assign o_cmd_pop    = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_clearing   = (r_state == ST_CLEAR);
    assign o_valid      = r_ovalid;
    assign o_best_value = r_obest;

    // evaluation operands
    always_comb begin
        e_k = r_k;
        e_x = r_coord_q;
        e_b = r_b;
        case (r_state)
            ST_E1: begin
                e_k = r_ck;
                e_x = r_x;
                e_b = r_cb;
            end
            ST_QE: begin
                e_k = r_node_k_q;
                e_x = r_x;
                e_b = r_node_b_q;
            end
            default: begin
                e_k = r_k;
                e_x = r_coord_q;
                e_b = r_b;
            end
        endcase
    end

    // memory addressing and node writes
    always_comb begin
        w_crd_we  = o_cmd_pop && (i_cmd.kind == K_LOAD);
        w_node_we = 1'b0;
        w_node_wa = r_n;
        w_node_wk = r_k;
        w_node_wb = r_b;
        case (r_p)
            PT_LO:   w_rd_pt = r_lo;
            PT_HI:   w_rd_pt = r_hi;
            default: w_rd_pt = w_mid;
        endcase
        if (r_state == ST_QA) begin
            w_rd_pt = r_pt;
        end
        w_crd_ra = CRD_AW'(w_rd_pt - 1'b1);
        if (r_state == ST_CLEAR) begin
            w_node_we = 1'b1;
            w_node_wa = r_clr;
            w_node_wk = '0;
            w_node_wb = '0;
        end else if (r_state == ST_DEC) begin
            if (r_p == PT_HI) begin
                w_node_we = !(ge_l && ge_r) && (le_l && le_r);
            end else begin
                w_node_we = (!(ge_l && ge_m) && le_l && le_m) ||
                            (!(ge_l && ge_m) && !(le_l && le_m) && !(ge_r && ge_m)
                             && le_r && le_m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_k[w_node_wa] <= w_node_wk;
            r_node_b[w_node_wa] <= w_node_wb;
        end
        r_node_k_q <= r_node_k[r_n];
        r_node_b_q <= r_node_b[r_n];
    end

    always_ff @(posedge i_clk) begin
        if (w_crd_we) begin
            r_coord[i_cmd.idx] <= i_cmd.coord;
        end
        r_coord_q <= r_coord[w_crd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
            r_p      <= PT_LO;
        end else begin
            if ((r_state == ST_QOUT) && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == NODE_W'(NODE_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_n     <= NODE_W'(1);
                        r_lo    <= PT_W'(1);
                        r_hi    <= PT_W'(LEAF_COUNT);
                        r_ilo   <= i_cmd.lo;
                        r_ihi   <= i_cmd.hi;
                        r_pt    <= i_cmd.pt;
                        r_k     <= i_cmd.slope;
                        r_b     <= i_cmd.icpt;
                        r_k0    <= i_cmd.slope;
                        r_b0    <= i_cmd.icpt;
                        r_first <= 1'b1;
                        r_sp    <= '0;
                        case (i_cmd.kind)
                            K_INSERT: r_state <= ST_VISIT;
                            K_QUERY:  r_state <= ST_QA;
                            default:  r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_VISIT: begin
                    if (w_cover) begin
                        r_p     <= PT_LO;
                        r_state <= ST_RD;
                    end else begin
                        if (w_go_r) begin
                            r_stk_n[r_sp[SP_W-2:0]]  <= w_nr;
                            r_stk_lo[r_sp[SP_W-2:0]] <= w_mid + 1'b1;
                            r_stk_hi[r_sp[SP_W-2:0]] <= r_hi;
                            r_sp                     <= r_sp + 1'b1;
                        end
                        if (w_go_l) begin
                            r_n  <= w_nl;
                            r_hi <= w_mid;
                        end else begin
                            r_state <= ST_POP;
                        end
                    end
                end
                ST_POP: begin
                    if (r_sp == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_n     <= r_stk_n[w_top];
                        r_lo    <= r_stk_lo[w_top];
                        r_hi    <= r_stk_hi[w_top];
                        r_sp    <= r_sp - 1'b1;
                        r_k     <= r_k0;
                        r_b     <= r_b0;
                        r_state <= ST_VISIT;
                    end
                end
                ST_RD: begin
                    r_state <= ST_X;
                end
                ST_X: begin
                    r_x <= r_coord_q;
                    if (r_p == PT_LO) begin
                        r_ck <= r_node_k_q;
                        r_cb <= r_node_b_q;
                    end
                    r_state <= ST_E1;
                end
                ST_E1: begin
                    r_state <= ST_E2;
                end
                ST_E2: begin
                    case (r_p)
                        PT_LO:   r_ln <= e_v;
                        PT_HI:   r_rn <= e_v;
                        default: r_mn <= e_v;
                    endcase
                    r_state <= ST_E3;
                end
                ST_E3: begin
                    case (r_p)
                        PT_LO: begin
                            r_lc    <= e_v;
                            r_p     <= PT_HI;
                            r_state <= ST_RD;
                        end
                        PT_HI: begin
                            r_rc    <= e_v;
                            r_state <= ST_DEC;
                        end
                        default: begin
                            r_mc    <= e_v;
                            r_state <= ST_DEC;
                        end
                    endcase
                end
                ST_DEC: begin
                    if (r_p == PT_HI) begin
                        if (!(ge_l && ge_r) && !(le_l && le_r)) begin
                            r_p     <= PT_MID;
                            r_state <= ST_RD;
                        end else begin
                            r_state <= ST_POP;
                        end
                    end else if (ge_l && ge_m) begin
                        r_n     <= w_nr;
                        r_lo    <= w_mid + 1'b1;
                        r_p     <= PT_LO;
                        r_state <= ST_RD;
                    end else if (le_l && le_m) begin
                        // new line wins the left half, old line moves right
                        r_n     <= w_nr;
                        r_lo    <= w_mid + 1'b1;
                        r_k     <= r_ck;
                        r_b     <= r_cb;
                        r_p     <= PT_LO;
                        r_state <= ST_RD;
                    end else if (ge_r && ge_m) begin
                        r_n     <= w_nl;
                        r_hi    <= w_mid;
                        r_p     <= PT_LO;
                        r_state <= ST_RD;
                    end else if (le_r && le_m) begin
                        r_n     <= w_nl;
                        r_hi    <= w_mid;
                        r_k     <= r_ck;
                        r_b     <= r_cb;
                        r_p     <= PT_LO;
                        r_state <= ST_RD;
                    end else begin
                        r_state <= ST_POP;
                    end
                end
                ST_QA: begin
                    r_state <= ST_QX;
                end
                ST_QX: begin
                    r_x     <= r_coord_q;
                    r_state <= ST_QN;
                end
                ST_QN: begin
                    r_state <= ST_QE;
                end
                ST_QE: begin
                    r_state <= ST_QW;
                end
                ST_QW: begin
                    r_state <= ST_QV;
                end
                ST_QV: begin
                    r_first <= 1'b0;
                    if (r_first || (e_v > r_best)) begin
                        r_best <= e_v;
                    end
                    if (r_lo == r_hi) begin
                        r_state <= ST_QOUT;
                    end else begin
                        if (r_pt <= w_mid) begin
                            r_n  <= w_nl;
                            r_hi <= w_mid;
                        end else begin
                            r_n  <= w_nr;
                            r_lo <= w_mid + 1'b1;
                        end
                        r_state <= ST_QN;
                    end
                end
                ST_QOUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_obest  <= r_best;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/li_chao_segment_max_core.sv @@
// li chao segment max: top level tying the front queue to the back sequencer
// depends on lcsm_pkg, lcsm_front, lcsm_back
//
// input channel: i_valid / o_stall, one item per transfer; mode selects load of one
// coordinate, insert of a line over a leaf range, or query of one leaf.
// output channel: o_valid / i_stall, one transfer of o_best_value per query.
// loads, inserts and mode 3 give nothing back; empty inserts are dropped at entry.
// a two-entry queue holds items while the sequencer works, so items are taken
// while a finished result still waits.
// load: stored on the pop. query: ST_QA, ST_QX, then per tree level (11 levels)
// ST_QN, ST_QE, ST_QW, ST_QV. insert: ST_VISIT per uncovered node, ST_POP per pop;
// a covered node runs ST_RD, ST_X, ST_E1, ST_E2, ST_E3 for its low, then high end,
// then ST_DEC; a needed middle point repeats those states; one shared line evaluator.
// reset: the node memory is cleared one node a cycle, all 2048 nodes, with o_stall
// high; the coordinate table is not cleared and must be loaded before use.
// when the receiver stalls, a finished result holds in the output register and
// the sequencer waits at the next query result.
`default_nettype none

module li_chao_segment_max_core
    import lcsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_mode,
    input  wire logic [9:0]          i_load_index,
    input  wire logic signed [31:0]  i_coord_value,
    input  wire logic [10:0]         i_range_low,
    input  wire logic [10:0]         i_range_high,
    input  wire logic signed [31:0]  i_slope,
    input  wire logic signed [63:0]  i_intercept,
    input  wire logic [10:0]         i_query_point,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [63:0]       o_best_value
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;
    logic w_clearing;

    lcsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_load_index  (i_load_index),
        .i_coord_value (i_coord_value),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_slope       (i_slope),
        .i_intercept   (i_intercept),
        .i_query_point (i_query_point),
        .i_clearing    (w_clearing),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    lcsm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_clearing   (w_clearing),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_best_value (o_best_value)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for li_chao_segment_max_core: loads ascending coordinates on the low leaves
// and last leaf, then random and directed items of all modes vs a line-tree predictor
// depends on lcsm_pkg and li_chao_segment_max_core
`default_nettype none

module testbench;
    import lcsm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // the initial table loads only the lower leaves and the last slot; ranges stay inside them
    localparam int USED_LEAVES = 256;

    typedef struct {
        logic [1:0]         mode;
        logic [9:0]         load_index;
        logic signed [31:0] coord_value;
        logic [10:0]        range_low;
        logic [10:0]        range_high;
        logic signed [31:0] slope;
        logic signed [63:0] intercept;
        logic [10:0]        query_point;
    } t_item;

    class lichao_scoreboard;
        logic signed [31:0] line_slope [0:4*LEAF_COUNT-1];
        logic signed [63:0] line_offset[0:4*LEAF_COUNT-1];
        logic signed [31:0] coords     [0:LEAF_COUNT-1];
        logic signed [63:0] expected_best[$];
        int unsigned        span_lo, span_hi;

        function new();
            foreach (line_slope[n]) begin
                line_slope[n]  = 0;
                line_offset[n] = 0;
            end
            foreach (coords[n]) coords[n] = 0;
        endfunction

        // product is exact, the sum saturates to 64 bits
        function logic signed [63:0] eval_line(logic signed [31:0] k, logic signed [63:0] b,
                                               int unsigned leaf);
            logic signed [63:0] p;
            logic signed [65:0] s;
            p = 64'(k) * 64'(coords[leaf-1]);
            s = 66'(p) + 66'(b);
            if (s > 66'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
            if (s < -66'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return s[63:0];
        endfunction

        function void place_line(int unsigned n, int unsigned lo, int unsigned hi,
                                 logic signed [31:0] k, logic signed [63:0] b);
            int unsigned mid;
            logic signed [31:0] ck;
            logic signed [63:0] cb, ln, lc, rn, rc, mn, mc;
            mid = (lo + hi) >> 1;
            if (n >= 4 * LEAF_COUNT) return;
            if (lo >= span_lo && hi <= span_hi) begin
                ck = line_slope[n];
                cb = line_offset[n];
                ln = eval_line(k, b, lo);
                lc = eval_line(ck, cb, lo);
                rn = eval_line(k, b, hi);
                rc = eval_line(ck, cb, hi);
                if (lc >= ln && rc >= rn) return;
                if (lc <= ln && rc <= rn) begin
                    line_slope[n] = k;
                    line_offset[n] = b;
                    return;
                end
                mn = eval_line(k, b, mid);
                mc = eval_line(ck, cb, mid);
                if (lc >= ln && mc >= mn) begin
                    place_line(2*n+1, mid+1, hi, k, b);
                end else if (lc <= ln && mc <= mn) begin
                    place_line(2*n+1, mid+1, hi, ck, cb);
                    line_slope[n] = k;
                    line_offset[n] = b;
                end else if (rc >= rn && mc >= mn) begin
                    place_line(2*n, lo, mid, k, b);
                end else if (rc <= rn && mc <= mn) begin
                    place_line(2*n, lo, mid, ck, cb);
                    line_slope[n] = k;
                    line_offset[n] = b;
                end
                return;
            end
            if (lo <= span_hi && mid >= span_lo) place_line(2*n, lo, mid, k, b);
            if (mid < span_hi && hi >= span_lo) place_line(2*n+1, mid+1, hi, k, b);
        endfunction

        function logic signed [63:0] best_at(int unsigned leaf);
            int unsigned n, lo, hi, mid;
            logic signed [63:0] best, v;
            n = 1;
            lo = 1;
            hi = LEAF_COUNT;
            best = eval_line(line_slope[1], line_offset[1], leaf);
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (leaf <= mid) begin
                    n = 2*n;
                    hi = mid;
                end else begin
                    n = 2*n + 1;
                    lo = mid + 1;
                end
                v = eval_line(line_slope[n], line_offset[n], leaf);
                if (v > best) best = v;
            end
            return best;
        endfunction

        function void note_input(t_item it);
            int unsigned p;
            case (it.mode)
                MODE_LOAD: coords[it.load_index] = it.coord_value;
                MODE_INSERT: begin
                    if (it.range_low <= it.range_high) begin
                        span_lo = it.range_low;
                        span_hi = it.range_high;
                        place_line(1, 1, LEAF_COUNT, it.slope, it.intercept);
                    end
                end
                MODE_QUERY: begin
                    p = it.query_point;
                    if (p < 1) p = 1;
                    if (p > LEAF_COUNT) p = LEAF_COUNT;
                    expected_best = {expected_best, best_at(p)};
                end
                default: ;
            endcase
        endfunction

        // 0 match, 1 wrong value, 2 nothing expected
        function int check_result(logic signed [63:0] got, output logic signed [63:0] want);
            want = 0;
            if (expected_best.size() == 0) return 2;
            want = expected_best.pop_front();
            return (got === want) ? 0 : 1;
        endfunction
    endclass

    logic               clk, rst_n, in_valid, in_stall_out, out_valid, out_stall;
    logic [1:0]         mode;
    logic [9:0]         load_index;
    logic signed [31:0] coord_value, slope;
    logic [10:0]        range_low, range_high, query_point;
    logic signed [63:0] intercept, best_value;

    lichao_scoreboard sb;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    li_chao_segment_max_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall_out),
        .i_mode(mode), .i_load_index(load_index), .i_coord_value(coord_value),
        .i_range_low(range_low), .i_range_high(range_high), .i_slope(slope),
        .i_intercept(intercept), .i_query_point(query_point), .o_valid(out_valid),
        .i_stall(out_stall), .o_best_value(best_value)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(string what, logic signed [63:0] got, logic signed [63:0] want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        logic signed [63:0] want;
        int r;
        if (rst_n && out_valid && !out_stall) begin
            r = sb.check_result(best_value, want);
            if (r == 2) report("unexpected best_value", best_value, 64'sd0);
            else if (r == 1) report("best_value", best_value, want);
        end
    end

    always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic send(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        mode = it.mode;
        load_index = it.load_index;
        coord_value = it.coord_value;
        range_low = it.range_low;
        range_high = it.range_high;
        slope = it.slope;
        intercept = it.intercept;
        query_point = it.query_point;
        do @(posedge clk); while (in_stall_out);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 0;
        while (sb.expected_best.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    function automatic t_item blank_item(logic [1:0] m);
        t_item it;
        it.mode = m;
        it.load_index = 10'($urandom);
        it.coord_value = $urandom;
        it.range_low = 11'($urandom);
        it.range_high = 11'($urandom);
        it.slope = $urandom;
        it.intercept = {$urandom, $urandom};
        it.query_point = 11'($urandom);
        return it;
    endfunction

    task automatic send_insert(int lo, int hi, logic signed [31:0] k, logic signed [63:0] b);
        t_item it;
        it = blank_item(MODE_INSERT);
        it.range_low = 11'(lo);
        it.range_high = 11'(hi);
        it.slope = k;
        it.intercept = b;
        send(it);
    endtask

    task automatic send_query(int p);
        t_item it;
        it = blank_item(MODE_QUERY);
        it.query_point = 11'(p);
        send(it);
    endtask

    task automatic random_item();
        t_item it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            it = blank_item(MODE_LOAD);
        end else if (pick < 48) begin
            it = blank_item(MODE_INSERT);
            if ($urandom_range(9) < 8) begin
                it.range_low = 11'($urandom_range(1, USED_LEAVES));
                it.range_high = 11'($urandom_range(it.range_low, USED_LEAVES));
            end else if ($urandom_range(1)) begin
                // empty range
                it.range_low = 11'($urandom_range(1, 2047));
                it.range_high = 11'($urandom_range(0, it.range_low - 1));
            end else begin
                it.range_low = 11'd0;
                it.range_high = 11'($urandom_range(USED_LEAVES));
            end
            // small slopes and offsets make lines cross inside the table
            if ($urandom_range(1)) begin
                it.slope = $signed($urandom_range(2000)) - 1000;
                it.intercept = 64'($signed($urandom)) * 1024;
            end
        end else if (pick < 96) begin
            it = blank_item(MODE_QUERY);
            if ($urandom_range(9) < 9) begin
                it.query_point = 11'($urandom_range(1, USED_LEAVES));
            end else if ($urandom_range(1)) begin
                it.query_point = 11'd0;
            end else begin
                it.query_point = 11'($urandom_range(LEAF_COUNT, 2047));
            end
        end else begin
            it = blank_item(MODE_UNUSED);
        end
        send(it);
    endtask

    initial begin
        t_item it;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        mode = MODE_LOAD;
        load_index = 0;
        coord_value = 0;
        range_low = 0;
        range_high = 0;
        slope = 0;
        intercept = 0;
        query_point = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;

        // strictly ascending coordinates on the lower leaves and the last leaf
        for (int i = 0; i < LEAF_COUNT; i++) begin
            if (i >= USED_LEAVES && i != LEAF_COUNT-1) continue;
            it = blank_item(MODE_LOAD);
            it.load_index = 10'(i);
            it.coord_value = 32'(-64'sd2147483648 + 64'(i) * 4194304
                + ((i == 0) ? 0 : (i == LEAF_COUNT-1) ? 4194303 : $urandom_range(4194303)));
            send(it);
        end

        // directed: queries on the empty tree, clamped points, edge inserts, mode 3, a reload
        send_query(0);
        send_query(1);
        send_query(LEAF_COUNT);
        send_query(2047);
        send_insert(5, 4, 100, 100);
        send_insert(0, USED_LEAVES, 32'sh7fffffff, 64'sh7fffffff_ffffffff);
        send_query(LEAF_COUNT);
        send_query(1);
        send_insert(1, USED_LEAVES, 32'sh80000000, 64'sh80000000_00000000);
        send_query(30);
        send_insert(128, 128, 0, 64'sd123456789);
        send_query(128);
        send_insert(100, USED_LEAVES, -7, 64'sd5000000000);
        send_insert(1, 200, 3, -64'sd9000000000);
        send(blank_item(MODE_UNUSED));
        send_query(150);
        send_query(250);
        it = blank_item(MODE_LOAD);
        it.load_index = 10'd200;
        it.coord_value = 32'sh7fffffff;
        send(it);
        send_query(201);
        drain();

        send_idle_pct = 28;
        recv_idle_pct = 68;
        repeat (55) random_item();
        drain();
        send_idle_pct = 68;
        recv_idle_pct = 28;
        repeat (55) random_item();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (55) random_item();
        drain();

        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
